// ----- hw/rtl/brdg_pkg.sv -----
// Shared constants and a clamp function for the blit row descriptor generator.
package brdg_pkg;

    // Request kinds on the input stream
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_NEXT  = 1'b1;

    // Blit operations
    localparam logic [1:0] OP_FILL       = 2'd0;
    localparam logic [1:0] OP_VID_TO_BUF = 2'd1;
    localparam logic [1:0] OP_BUF_TO_VID = 2'd2;
    localparam logic [1:0] OP_VID_TO_VID = 2'd3;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_BASE      = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PIXELS_PER_LINE = 4'd1;

    // Geometry
    localparam int unsigned COORD_W  = 12;
    localparam int unsigned SIZE_W   = 13;
    localparam int unsigned STRIDE_W = 16;
    localparam int unsigned ADDR_W   = 32;
    localparam int unsigned PIXEL_W  = 32;
    localparam int unsigned COUNT_W  = 15;
    localparam int unsigned PROD_W   = SIZE_W + STRIDE_W;
    localparam logic [SIZE_W-1:0] MAX_COORD = 13'd4096;
    localparam logic [SIZE_W-1:0] PPL_RESET = 13'd640;
    localparam logic [COUNT_W-1:0] MAX_BYTES = 15'd16384;

    // Stream widths
    localparam int unsigned S_TDATA_W = 160;
    localparam int unsigned S_TUSER_W = 3;
    localparam int unsigned M_TDATA_W = 112;

    // Width or height above the largest rectangle is clamped
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
        clamp_size = (v > MAX_COORD) ? MAX_COORD : v;
    endfunction

endpackage

// ----- hw/rtl/blit_row_descriptor_generator.sv -----
// Blit row descriptor generator: turns rectangle commands into per-row transfer descriptors.
//
// Usage
//   Slave stream (s_t*): one transfer per request. tuser bit 0 selects a start
//   command (0) or a next-row request (1); a start latches the rectangle and
//   issues its top row, each next-row request issues the following row.
//   Master stream (m_t*): one descriptor per issued row, tlast on the last
//   row of the rectangle, tuser high for fill rows.
//   Config channel (i_cfg_*): frame_base and pixels_per_line, which the user
//   must write only while the block is idle (not enforced); always ready.
// Timing
//   Three register stages: request (row picked, base plus column offset),
//   product (row times pitch, one 13x16 multiply per side), descriptor (final
//   address add). A descriptor passes through these three registers in that
//   order on its way to m_t*. One request is taken every cycle while the
//   pipeline is not stalled, each stage moving one row on. A start with zero
//   height or a next-row request while idle is taken but yields no descriptor.
// Reset: synchronous, active low; pipeline emptied, block idle, registers
//   back to frame_base 0 and pixels_per_line 640.
// Stall: each stage holds while the one after it is full and blocked, so
//   requests keep flowing until all three stages hold descriptors.
module blit_row_descriptor_generator (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // tdata: src_x[11:0], src_y[23:12], dst_x[35:24], dst_y[47:36],
    //        rect_width[60:48], rect_height[73:61], row_stride[89:74],
    //        buffer_addr[121:90], fill_pixel[153:122], zero pad[159:154]
    input  logic [brdg_pkg::S_TDATA_W-1:0]        s_tdata,
    // tuser: req_type[0], operation[2:1]
    input  logic [brdg_pkg::S_TUSER_W-1:0]        s_tuser,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // tdata: src_addr[31:0], dst_addr[63:32], byte_count[78:64],
    //        fill_value[110:79], zero pad[111]
    output logic [brdg_pkg::M_TDATA_W-1:0]        m_tdata,
    // tuser: is_fill[0]
    output logic                                  m_tuser,
    output logic                                  m_tlast,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // configuration write channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [brdg_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [31:0]                           i_cfg_data
);

    // Request stage: one row picked, bases already offset by the column
    typedef struct packed {
        logic                                is_fill;
        logic                                src_zero;
        logic                                src_fb;
        logic                                dst_fb;
        logic [brdg_pkg::ADDR_W-1:0]         src_base;
        logic [brdg_pkg::ADDR_W-1:0]         dst_base;
        logic [brdg_pkg::SIZE_W-1:0]         src_y;
        logic [brdg_pkg::SIZE_W-1:0]         dst_y;
        logic [brdg_pkg::STRIDE_W-1:0]       src_pitch;
        logic [brdg_pkg::STRIDE_W-1:0]       dst_pitch;
        logic [brdg_pkg::COUNT_W-1:0]        byte_count;
        logic [brdg_pkg::PIXEL_W-1:0]        fill_value;
        logic                                last;
    } t_req;

    // Product stage
    typedef struct packed {
        logic                                is_fill;
        logic                                src_zero;
        logic                                src_fb;
        logic                                dst_fb;
        logic [brdg_pkg::ADDR_W-1:0]         src_base;
        logic [brdg_pkg::ADDR_W-1:0]         dst_base;
        logic [brdg_pkg::PROD_W-1:0]         src_prod;
        logic [brdg_pkg::PROD_W-1:0]         dst_prod;
        logic [brdg_pkg::COUNT_W-1:0]        byte_count;
        logic [brdg_pkg::PIXEL_W-1:0]        fill_value;
        logic                                last;
    } t_prod;

    // Configuration
    logic [brdg_pkg::ADDR_W-1:0]   r_frame_base;
    logic [brdg_pkg::SIZE_W-1:0]   r_pixels_per_line;

    // Command state
    logic                          r_busy;
    logic [1:0]                    r_operation;
    logic [brdg_pkg::COORD_W-1:0]  r_row_index;
    logic [brdg_pkg::SIZE_W-1:0]   r_rows_total;
    logic [brdg_pkg::COORD_W-1:0]  r_src_x, r_src_y, r_dst_x, r_dst_y;
    logic [brdg_pkg::SIZE_W-1:0]   r_width;
    logic [brdg_pkg::STRIDE_W-1:0] r_stride;
    logic [brdg_pkg::ADDR_W-1:0]   r_buffer;
    logic [brdg_pkg::PIXEL_W-1:0]  r_fill;

    // Pipeline
    logic                          r_req_valid, r_prod_valid, r_out_valid;
    t_req                          r_req;
    t_prod                         r_prod;
    t_req                          n_req;
    t_prod                         n_prod;
    logic [brdg_pkg::ADDR_W-1:0]   r_src_addr, r_dst_addr, n_src_addr, n_dst_addr;
    logic [brdg_pkg::COUNT_W-1:0]  r_byte_count;
    logic [brdg_pkg::PIXEL_W-1:0]  r_fill_value;
    logic                          r_is_fill, r_last;

    logic                          out_ready, prod_ready, req_ready;
    logic                          s_fire;

    // Decoded request
    logic                          is_start;
    logic [1:0]                    in_op;
    logic [brdg_pkg::COORD_W-1:0]  in_src_x, in_src_y, in_dst_x, in_dst_y;
    logic [brdg_pkg::SIZE_W-1:0]   in_width, in_height;
    logic [brdg_pkg::STRIDE_W-1:0] in_stride_raw, in_stride;
    logic [brdg_pkg::ADDR_W-1:0]   in_buffer;
    logic [brdg_pkg::PIXEL_W-1:0]  in_fill;

    // Selected command (incoming on a start, saved otherwise)
    logic [1:0]                    sel_op;
    logic [brdg_pkg::COORD_W-1:0]  sel_src_x, sel_src_y, sel_dst_x, sel_dst_y;
    logic [brdg_pkg::COORD_W-1:0]  sel_row;
    logic [brdg_pkg::SIZE_W-1:0]   sel_rows_total, sel_width;
    logic [brdg_pkg::STRIDE_W-1:0] sel_stride;
    logic [brdg_pkg::ADDR_W-1:0]   sel_buffer;
    logic [brdg_pkg::PIXEL_W-1:0]  sel_fill;
    logic [brdg_pkg::SIZE_W-1:0]   next_row;
    logic                          emit, row_last;
    logic                          src_buf, dst_buf;

    logic [brdg_pkg::ADDR_W-1:0]   src_term, dst_term;

    assign out_ready  = !r_out_valid  || m_tready;
    assign prod_ready = !r_prod_valid || out_ready;
    assign req_ready  = !r_req_valid  || prod_ready;
    assign s_tready   = req_ready;
    assign s_fire     = s_tvalid && s_tready;
    assign o_cfg_ready = 1'b1;

    // ---- request decode ----
    assign is_start      = (s_tuser[0] == brdg_pkg::REQ_START);
    assign in_op         = s_tuser[2:1];
    assign in_src_x      = s_tdata[11:0];
    assign in_src_y      = s_tdata[23:12];
    assign in_dst_x      = s_tdata[35:24];
    assign in_dst_y      = s_tdata[47:36];
    assign in_width      = brdg_pkg::clamp_size(s_tdata[60:48]);
    assign in_height     = brdg_pkg::clamp_size(s_tdata[73:61]);
    assign in_stride_raw = s_tdata[89:74];
    assign in_buffer     = s_tdata[121:90];
    assign in_fill       = s_tdata[153:122];
    // zero stride means a tightly packed buffer
    assign in_stride     = (in_stride_raw == '0) ? {1'b0, in_width, 2'b00} : in_stride_raw;

    always_comb begin
        if (is_start) begin
            sel_op         = in_op;
            sel_src_x      = in_src_x;
            sel_src_y      = in_src_y;
            sel_dst_x      = in_dst_x;
            sel_dst_y      = in_dst_y;
            sel_row        = '0;
            sel_rows_total = in_height;
            sel_width      = in_width;
            sel_stride     = in_stride;
            sel_buffer     = in_buffer;
            sel_fill       = in_fill;
            emit           = (in_height != '0);
        end else begin
            sel_op         = r_operation;
            sel_src_x      = r_src_x;
            sel_src_y      = r_src_y;
            sel_dst_x      = r_dst_x;
            sel_dst_y      = r_dst_y;
            sel_row        = r_row_index;
            sel_rows_total = r_rows_total;
            sel_width      = r_width;
            sel_stride     = r_stride;
            sel_buffer     = r_buffer;
            sel_fill       = r_fill;
            emit           = r_busy;
        end
    end

    assign next_row = {1'b0, sel_row} + 13'd1;
    assign row_last = (next_row >= sel_rows_total);
    assign src_buf  = (sel_op == brdg_pkg::OP_BUF_TO_VID);
    assign dst_buf  = (sel_op == brdg_pkg::OP_VID_TO_BUF);

    always_comb begin
        n_req.is_fill    = (sel_op == brdg_pkg::OP_FILL);
        n_req.src_zero   = (sel_op == brdg_pkg::OP_FILL);
        n_req.src_fb     = !src_buf;
        n_req.dst_fb     = !dst_buf;
        n_req.src_base   = (src_buf ? sel_buffer : r_frame_base)
                         + {18'd0, sel_src_x, 2'b00};
        n_req.dst_base   = (dst_buf ? sel_buffer : r_frame_base)
                         + {18'd0, sel_dst_x, 2'b00};
        n_req.src_y      = {1'b0, sel_src_y} + {1'b0, sel_row};
        n_req.dst_y      = {1'b0, sel_dst_y} + {1'b0, sel_row};
        n_req.src_pitch  = src_buf ? sel_stride : {3'd0, r_pixels_per_line};
        n_req.dst_pitch  = dst_buf ? sel_stride : {3'd0, r_pixels_per_line};
        n_req.byte_count = {sel_width, 2'b00};
        n_req.fill_value = (sel_op == brdg_pkg::OP_FILL) ? sel_fill : '0;
        n_req.last       = row_last;
    end

    // ---- product stage ----
    always_comb begin
        n_prod.is_fill    = r_req.is_fill;
        n_prod.src_zero   = r_req.src_zero;
        n_prod.src_fb     = r_req.src_fb;
        n_prod.dst_fb     = r_req.dst_fb;
        n_prod.src_base   = r_req.src_base;
        n_prod.dst_base   = r_req.dst_base;
        n_prod.src_prod   = {16'd0, r_req.src_y} * {13'd0, r_req.src_pitch};
        n_prod.dst_prod   = {16'd0, r_req.dst_y} * {13'd0, r_req.dst_pitch};
        n_prod.byte_count = r_req.byte_count;
        n_prod.fill_value = r_req.fill_value;
        n_prod.last       = r_req.last;
    end

    // ---- address stage: framebuffer pitch is in pixels, buffer pitch in bytes ----
    assign src_term   = r_prod.src_fb ? {1'b0, r_prod.src_prod, 2'b00}
                                      : {3'd0, r_prod.src_prod};
    assign dst_term   = r_prod.dst_fb ? {1'b0, r_prod.dst_prod, 2'b00}
                                      : {3'd0, r_prod.dst_prod};
    assign n_src_addr = r_prod.src_zero ? '0 : (r_prod.src_base + src_term);
    assign n_dst_addr = r_prod.dst_base + dst_term;

    // ---- configuration ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_base      <= '0;
            r_pixels_per_line <= brdg_pkg::PPL_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                brdg_pkg::REG_FRAME_BASE:      r_frame_base      <= i_cfg_data;
                brdg_pkg::REG_PIXELS_PER_LINE: r_pixels_per_line <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // ---- command state ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_row_index <= '0;
        end else if (s_fire && (is_start || r_busy)) begin
            r_row_index <= next_row[brdg_pkg::COORD_W-1:0];
            r_busy      <= emit && !row_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire && is_start) begin
            r_operation  <= in_op;
            r_src_x      <= in_src_x;
            r_src_y      <= in_src_y;
            r_dst_x      <= in_dst_x;
            r_dst_y      <= in_dst_y;
            r_width      <= in_width;
            r_stride     <= in_stride;
            r_buffer     <= in_buffer;
            r_fill       <= in_fill;
            r_rows_total <= in_height;
        end
    end

    // ---- pipeline valids ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid  <= 1'b0;
            r_prod_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (req_ready)  r_req_valid  <= s_fire && emit;
            if (prod_ready) r_prod_valid <= r_req_valid;
            if (out_ready)  r_out_valid  <= r_prod_valid;
        end
    end

    // ---- pipeline payload ----
    always_ff @(posedge i_clk) begin
        if (req_ready) begin
            r_req <= n_req;
        end
        if (prod_ready) begin
            r_prod <= n_prod;
        end
        if (out_ready) begin
            r_src_addr   <= n_src_addr;
            r_dst_addr   <= n_dst_addr;
            r_byte_count <= r_prod.byte_count;
            r_fill_value <= r_prod.fill_value;
            r_is_fill    <= r_prod.is_fill;
            r_last       <= r_prod.last;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {1'b0, r_fill_value, r_byte_count, r_dst_addr, r_src_addr};
    assign m_tuser  = r_is_fill;
    assign m_tlast  = r_last;

`ifndef SYNTHESIS
    // a next-row request while a command runs always yields a descriptor
    a_next_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_fire && !is_start && r_busy) |=> r_req_valid)
        else $error("next-row request while busy produced no descriptor");

    // busy drops on the edge the last row enters the request stage
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_req_valid && r_req.last) |-> !r_busy)
        else $error("still busy after last row issued");

    // while busy the next row index stays inside the rectangle
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> ({1'b0, r_row_index} < r_rows_total))
        else $error("row index beyond rectangle height");

    // the input side only stalls when every stage is full
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_tready |-> (r_req_valid && r_prod_valid && r_out_valid))
        else $error("input stalled with a free stage");

    // row byte count never exceeds the widest rectangle
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_byte_count <= brdg_pkg::MAX_BYTES))
        else $error("byte count out of range");
`endif

endmodule
